[hdl/sine_cosine_height_pattern_defines.svh]
// assertion macros shared by the height pattern rtl
`ifndef SINE_COSINE_HEIGHT_PATTERN_DEFINES_SVH
`define SINE_COSINE_HEIGHT_PATTERN_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define SCHP_CHECK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition that must hold in the clock after a trigger
`define SCHP_CHECK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/schp_pkg.sv]
// types, constants and sine table builder for the height pattern block
`timescale 1ns / 1ps

package schp_pkg;

   localparam int HEIGHT_BITS      = 16;
   localparam int COORD_FIELD_BITS = 12;
   localparam int PHASE_BITS       = 16;
   localparam int CSR_INDEX_BITS   = 2;
   localparam int TBL_IDX_MAX_BITS = 13;
   localparam int QUEUE_DEPTH      = 2;
   localparam int QUEUE_PTR_BITS   = 1;
   localparam int QUEUE_CNT_BITS   = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_PHASE_STEP = 2'd0,
      CSR_AMPLITUDE  = 2'd1,
      CSR_HEIGHT_MIN = 2'd2,
      CSR_HEIGHT_MAX = 2'd3
   } csr_index_type;

   localparam logic [15:0]        RST_PHASE_STEP = 16'd0;
   localparam logic [15:0]        RST_AMPLITUDE  = 16'd16384;
   localparam logic signed [15:0] RST_HEIGHT_MIN = -16'sd32768;
   localparam logic signed [15:0] RST_HEIGHT_MAX = 16'sd32767;

   typedef struct packed {
      logic [COORD_FIELD_BITS-1:0] col;
      logic [COORD_FIELD_BITS-1:0] row;
   } req_type;

   typedef struct packed {
      logic signed [HEIGHT_BITS-1:0] height;
      logic                          clamped;
   } rsp_type;

   typedef struct packed {
      logic [PHASE_BITS-1:0]         phase_step;
      logic [15:0]                   amplitude;
      logic signed [HEIGHT_BITS-1:0] height_min;
      logic signed [HEIGHT_BITS-1:0] height_max;
   } cfg_type;

   typedef struct packed {
      logic [TBL_IDX_MAX_BITS-1:0] sin_idx;
      logic                        sin_neg;
      logic [TBL_IDX_MAX_BITS-1:0] cos_idx;
      logic                        cos_neg;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic full_next;
   } queue_status_type;

   // quarter-wave entry, q30 taylor series rounded to q15
   function automatic logic [15:0] sine_entry(input int unsigned idx, input int unsigned stb);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] acc;
      logic [63:0]        v;
      x    = (64'd1686629713 * 64'(idx)) >> (stb - 2);
      x2   = (x * x) >> 30;
      term = x;
      acc  = signed'(x);
      term = ((term * x2) >> 30) / 64'd6;
      acc  = acc - signed'(term);
      term = ((term * x2) >> 30) / 64'd20;
      acc  = acc + signed'(term);
      term = ((term * x2) >> 30) / 64'd42;
      acc  = acc - signed'(term);
      term = ((term * x2) >> 30) / 64'd72;
      acc  = acc + signed'(term);
      term = ((term * x2) >> 30) / 64'd110;
      acc  = acc - signed'(term);
      term = ((term * x2) >> 30) / 64'd156;
      acc  = acc + signed'(term);
      term = ((term * x2) >> 30) / 64'd210;
      acc  = acc - signed'(term);
      if (acc < 0) begin
         acc = 0;
      end
      v = (unsigned'(acc) + 64'd16384) >> 15;
      if (v > 64'd32768) begin
         v = 64'd32768;
      end
      return v[15:0];
   endfunction

endpackage

[hdl/sine_cosine_height_pattern.sv]
// top level of the sine-cosine height pattern generator
//
//   channel   ports                              handshake
//   request   start, busy, req_item              accepted when start and not busy
//   response  rsp_valid, rsp_item                one-cycle strobe, never held off
//   csr       csr_valid, csr_ready, csr_index,   written when valid and ready
//             csr_data
//
// one grid point per clock sustained while busy stays low
// acceptance to result strobe: phase register, queue slot, then eight back-end register stages
// synchronous reset restores the register defaults and empties the pipeline
// busy rises only when the front-to-back queue would overflow
`timescale 1ns / 1ps

module sine_cosine_height_pattern #(
   parameter int COORD_BITS      = 12,
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  schp_pkg::req_type                     req_item,
   output logic                                  rsp_valid,
   output schp_pkg::rsp_type                     rsp_item,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [schp_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [15:0]                           csr_data
);

   schp_pkg::cfg_type          cfg_ff, cfg_in;
   schp_pkg::queue_status_type q_status;
   schp_pkg::entry_type        push_entry, pop_entry;
   logic                       push, pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (schp_pkg::csr_index_type'(csr_index))
            schp_pkg::CSR_PHASE_STEP: cfg_in.phase_step = csr_data;
            schp_pkg::CSR_AMPLITUDE:  cfg_in.amplitude  = csr_data;
            schp_pkg::CSR_HEIGHT_MIN: cfg_in.height_min = signed'(csr_data);
            schp_pkg::CSR_HEIGHT_MAX: cfg_in.height_max = signed'(csr_data);
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_step <= schp_pkg::RST_PHASE_STEP;
         cfg_ff.amplitude  <= schp_pkg::RST_AMPLITUDE;
         cfg_ff.height_min <= schp_pkg::RST_HEIGHT_MIN;
         cfg_ff.height_max <= schp_pkg::RST_HEIGHT_MAX;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   schp_front #(
      .COORD_BITS      (COORD_BITS),
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_item   (req_item),
      .phase_step (cfg_ff.phase_step),
      .q_status   (q_status),
      .busy       (busy),
      .push       (push),
      .push_entry (push_entry)
   );

   schp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .q_status   (q_status)
   );

   schp_back #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_status  (q_status),
      .q_entry   (pop_entry),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

[hdl/schp_front.sv]
// front end: takes grid points, forms both phases and table addresses
`timescale 1ns / 1ps

module schp_front #(
   parameter int COORD_BITS      = 12,
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  schp_pkg::req_type          req_item,
   input  logic [15:0]                phase_step,
   input  schp_pkg::queue_status_type q_status,
   output logic                       busy,
   output logic                       push,
   output schp_pkg::entry_type        push_entry
);

   localparam int USE_BITS = (COORD_BITS < schp_pkg::COORD_FIELD_BITS) ?
                             COORD_BITS : schp_pkg::COORD_FIELD_BITS;
   localparam int STB = SINE_TABLE_BITS;
   localparam int IB  = STB - 1;
   localparam int TW  = schp_pkg::TBL_IDX_MAX_BITS;
   localparam logic [IB-1:0] QLEN_V = {1'b1, {(STB-2){1'b0}}};

   logic                  f_valid_ff, f_valid_in;
   logic [15:0]           px_ff, px_in;
   logic [15:0]           py_ff, py_in;
   logic [USE_BITS-1:0]   col_use, row_use;
   logic [USE_BITS+15:0]  prod_x, prod_y;
   logic [IB:0]           sin_c, cos_c;

   // sign in the top bit, mirrored quarter-wave address below
   function automatic logic [IB:0] classify(input logic [15:0] ph);
      logic [STB-1:0] idx;
      logic [IB-1:0]  k;
      idx = ph[15 -: STB];
      k   = {1'b0, idx[STB-3:0]};
      return {idx[STB-1], (idx[STB-2] ? (QLEN_V - k) : k)};
   endfunction

   assign busy = q_status.full_next;

   always_comb begin
      col_use    = req_item.col[USE_BITS-1:0];
      row_use    = req_item.row[USE_BITS-1:0];
      prod_x     = col_use * phase_step;
      prod_y     = row_use * phase_step;
      px_in      = prod_x[15:0];
      py_in      = prod_y[15:0] + 16'h4000;
      f_valid_in = start && !busy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= f_valid_in;
      end
      px_ff <= px_in;
      py_ff <= py_in;
   end

   always_comb begin
      sin_c              = classify(px_ff);
      cos_c              = classify(py_ff);
      push               = f_valid_ff;
      push_entry.sin_idx = TW'(sin_c[IB-1:0]);
      push_entry.sin_neg = sin_c[IB];
      push_entry.cos_idx = TW'(cos_c[IB-1:0]);
      push_entry.cos_neg = cos_c[IB];
   end

endmodule

[hdl/schp_queue.sv]
// short queue between the front and back ends
`timescale 1ns / 1ps
`include "sine_cosine_height_pattern_defines.svh"

module schp_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  schp_pkg::entry_type        push_entry,
   input  logic                       pop,
   output schp_pkg::entry_type        pop_entry,
   output schp_pkg::queue_status_type q_status
);

   localparam int PW = schp_pkg::QUEUE_PTR_BITS;
   localparam int CW = schp_pkg::QUEUE_CNT_BITS;
   localparam logic [CW-1:0] DEPTH_V = CW'(schp_pkg::QUEUE_DEPTH);

   schp_pkg::entry_type slot_ff [schp_pkg::QUEUE_DEPTH];
   logic [PW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]       count_ff, count_in;
   logic                do_push, do_pop;

   always_comb begin
      q_status.empty     = (count_ff == '0);
      q_status.full      = (count_ff == DEPTH_V);
      do_push            = push && !q_status.full;
      do_pop             = pop && !q_status.empty;
      wr_ptr_in          = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in          = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in           = count_ff + CW'(do_push) - CW'(do_pop);
      q_status.full_next = (count_in == DEPTH_V);
      pop_entry          = slot_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `SCHP_CHECK(a_no_overflow, clock, reset, !(push && q_status.full), "push into full queue")
   `SCHP_CHECK_NEXT(a_count_up, clock, reset, do_push && !do_pop,
      count_ff == $past(count_ff) + 1'b1, "queue count lost a transaction")

endmodule

[hdl/schp_back.sv]
// back end: table lookup, product, scaling, rounding and clamp
`timescale 1ns / 1ps
`include "sine_cosine_height_pattern_defines.svh"

module schp_back #(
   parameter int SINE_TABLE_BITS = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  schp_pkg::cfg_type          cfg,
   input  schp_pkg::queue_status_type q_status,
   input  schp_pkg::entry_type        q_entry,
   output logic                       pop,
   output logic                       rsp_valid,
   output schp_pkg::rsp_type          rsp_item
);

   localparam int STB  = SINE_TABLE_BITS;
   localparam int IB   = STB - 1;
   localparam int QLEN = 1 << (STB - 2);
   localparam int HB   = schp_pkg::HEIGHT_BITS;

   logic [15:0] sine_tbl [QLEN+1];

   for (genvar g = 0; g <= QLEN; g++) begin : g_tbl
      localparam logic [15:0] ENTRY = schp_pkg::sine_entry(g, STB);
      assign sine_tbl[g] = ENTRY;
   end

   logic [6:0]          v_ff, v_in;
   logic                rsp_valid_ff;
   logic signed [16:0]  s_ff, s_in, c_ff, c_in;
   logic signed [33:0]  prod_ff, prod_in, prod_rnd;
   logic signed [16:0]  p15_ff, p15_in;
   logic signed [16:0]  amp_s;
   logic signed [33:0]  m_ff, m_in, m_rnd;
   logic signed [17:0]  w_ff, w_in;
   logic signed [16:0]  lim_sum, lim_diff;
   logic signed [34:0]  mw_ff, mw_in;
   logic signed [31:0]  ms_ff, ms_in;
   logic signed [35:0]  num;
   logic signed [19:0]  h_ff, h_in;
   logic signed [19:0]  lo20, hi20, h_lo;
   logic                hit_lo, hit_hi;
   schp_pkg::rsp_type   rsp_ff, rsp_in;
   logic [15:0]         s_mag, c_mag;

   assign pop = !q_status.empty;

   always_comb begin
      v_in     = {v_ff[5:0], pop};
      s_mag    = sine_tbl[q_entry.sin_idx[IB-1:0]];
      c_mag    = sine_tbl[q_entry.cos_idx[IB-1:0]];
      s_in     = q_entry.sin_neg ? -signed'({1'b0, s_mag}) : signed'({1'b0, s_mag});
      c_in     = q_entry.cos_neg ? -signed'({1'b0, c_mag}) : signed'({1'b0, c_mag});
      prod_in  = s_ff * c_ff;
      prod_rnd = prod_ff + 34'sd16384;
      p15_in   = prod_rnd[31:15];
      amp_s    = signed'({1'b0, cfg.amplitude});
      m_in     = amp_s * p15_ff;
      m_rnd    = m_ff + 34'sd8192;
      w_in     = m_rnd[31:14];
      lim_sum  = {cfg.height_min[HB-1], cfg.height_min}
               + {cfg.height_max[HB-1], cfg.height_max};
      lim_diff = {cfg.height_max[HB-1], cfg.height_max}
               - {cfg.height_min[HB-1], cfg.height_min};
      mw_in    = w_ff * lim_diff;
      ms_in    = signed'({lim_sum, 15'b0});
      num      = 36'(mw_ff) + 36'(ms_ff) + 36'sd32768;
      h_in     = num[35:16];
      // lower limit first, then upper
      lo20     = 20'(cfg.height_min);
      hi20     = 20'(cfg.height_max);
      hit_lo   = (h_ff < lo20);
      h_lo     = hit_lo ? lo20 : h_ff;
      hit_hi   = (h_lo > hi20);
      rsp_in.height  = hit_hi ? hi20[HB-1:0] : h_lo[HB-1:0];
      rsp_in.clamped = hit_lo || hit_hi;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         v_ff         <= v_in;
         rsp_valid_ff <= v_ff[6];
      end
      s_ff    <= s_in;
      c_ff    <= c_in;
      prod_ff <= prod_in;
      p15_ff  <= p15_in;
      m_ff    <= m_in;
      w_ff    <= w_in;
      mw_ff   <= mw_in;
      ms_ff   <= ms_in;
      h_ff    <= h_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   `SCHP_CHECK(a_in_limits, clock, reset,
      (rsp_valid && (cfg.height_min <= cfg.height_max)) |->
      ((rsp_item.height >= cfg.height_min) && (rsp_item.height <= cfg.height_max)),
      "height outside limits")
   `SCHP_CHECK(a_reversed, clock, reset,
      (rsp_valid && (cfg.height_min > cfg.height_max)) |->
      ((rsp_item.height == cfg.height_max) && rsp_item.clamped),
      "reversed limits not at max")

endmodule
